### hw/rtl/colstd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// colstd_pkg
// Shared types and constants for the column standardizer.
// ----------------------------------------------------------------------------
package colstd_pkg;

  localparam int MaxSamplesDef = 64;
  localparam int SampleW       = 32;
  localparam int DevW          = 39;   // exact n*x - sum
  localparam int MagW          = 38;   // magnitude of a deviation
  localparam int ScW           = 29;   // scaled magnitude width
  localparam int NumW          = ScW + 31;  // e*2^30 plus half the root, with carry
  localparam int SqW           = 64;   // sum of squares
  localparam int RootW         = 32;
  localparam int QuoW          = 33;   // quotient bits kept (saturation seen)
  localparam int LenW          = 6;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusZeroDev  = 2'd1;
  localparam logic [1:0] StatusOverflow = 2'd2;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_MAXRD,
    ST_MAX,
    ST_SQRD,
    ST_SQ,
    ST_ROOT,
    ST_EMRD,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage : colstd_pkg
`default_nettype wire

### hw/rtl/column_standardizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// column_standardizer
// Buffers one column of Q16.16 samples and emits each as a Q2.30 z-score
// scaled by 1/sqrt(n).
// ----------------------------------------------------------------------------
// Channel  | Handshake                   | Fields                           | Dir
// sample   | sample_valid, sample_ready  | sample, last_sample              | in
// result   | result_valid, result_ready  | normalized, last_result, status  | out
//
// Loading accepts one sample per cycle in the load state. On the marked sample the block runs a
// max pass, a sum-of-squares pass and a bit-pair square root, then for each
// sample a memory read, a capture cycle, a launch cycle, the 60-step shared
// divider and a done cycle before the result is offered.
// Reset is synchronous; the buffer holds no reset. A stalled result holds
// the sequencer in the output state.
// ----------------------------------------------------------------------------
module column_standardizer #(
  parameter int MAX_SAMPLES = colstd_pkg::MaxSamplesDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        sample_valid,
  output logic             sample_ready,
  input  wire logic [31:0] sample,
  input  wire logic        last_sample,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic [31:0]      normalized,
  output logic             last_result,
  output logic [1:0]       status
);

  localparam int IdxW   = $clog2(MAX_SAMPLES);
  localparam int CntW   = $clog2(MAX_SAMPLES + 1);
  localparam int SumW   = 38;
  localparam int DevW   = colstd_pkg::DevW;
  localparam int MagW   = colstd_pkg::MagW;
  localparam int ScW    = colstd_pkg::ScW;
  localparam int NumW   = colstd_pkg::NumW;
  localparam int LenMax = 5;

  colstd_pkg::state_t state, state_next;

  // Sample buffer
  logic signed [31:0] store [MAX_SAMPLES];
  logic signed [31:0] rd_data;
  logic [IdxW-1:0]    rd_addr;

  logic [CntW-1:0]        count;
  logic signed [SumW-1:0] sum;
  logic                   ovf;
  logic                   nonzero;
  logic [CntW-1:0]        idx;
  logic [MagW-1:0]        maxmag;
  logic [colstd_pkg::SqW-1:0] sq_acc;
  logic [ScW-1:0]         sc_mag;
  logic                   sc_neg;
  logic [ScW*2-1:0]       sq_prod;
  logic [colstd_pkg::RootW-1:0] root;
  logic [colstd_pkg::SqW-1:0]   rt_v;
  logic [5:0]             rt_step;
  logic [31:0]            out_val;
  logic                   div_armed;
  logic                   div_launched;

  // Deviation of the word just read
  logic signed [DevW-1:0] dev;
  logic                   dev_neg;
  logic [MagW-1:0]        dev_mag;
  logic [LenMax:0]        len;
  logic [ScW-1:0]         scaled;

  assign dev = DevW'($signed({1'b0, count})) * DevW'(rd_data) - DevW'(sum);
  assign dev_neg = dev[DevW-1];
  assign dev_mag = dev_neg ? MagW'(-dev) : MagW'(dev);

  // Bit length of the largest magnitude
  always_comb begin
    len = '0;
    for (int b = 0; b < MagW; b++) begin
      if (maxmag[b]) len = (LenMax+1)'(b + 1);
    end
  end

  // Align to [2^28, 2^29): left shift when short, truncating right otherwise
  always_comb begin
    if (len > (LenMax+1)'(ScW)) scaled = ScW'(dev_mag >> (len - (LenMax+1)'(ScW)));
    else                        scaled = ScW'(dev_mag << ((LenMax+1)'(ScW) - len));
  end

  // Divider
  logic                       dv_start, dv_done;
  logic [NumW-1:0]            dv_num;
  logic [colstd_pkg::QuoW-1:0] dv_quo;

  // Operands come from registers only: sc_mag is captured in the cycle before the launch
  assign dv_num = NumW'({sc_mag, 30'd0}) + NumW'(root >> 1);

  colstd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (dv_num),
    .divisor  (root),
    .done     (dv_done),
    .quotient (dv_quo)
  );

  // Buffer write and registered read
  always_ff @(posedge clk) begin
    if (state == colstd_pkg::ST_LOAD && sample_valid && count < CntW'(MAX_SAMPLES)) begin
      store[count[IdxW-1:0]] <= sample;
    end
    rd_data <= store[rd_addr];
  end
  assign rd_addr = idx[IdxW-1:0];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      colstd_pkg::ST_LOAD:  if (sample_valid && last_sample)
                              state_next = colstd_pkg::ST_MAXRD;
      colstd_pkg::ST_MAXRD: state_next = colstd_pkg::ST_MAX;
      colstd_pkg::ST_MAX:   if (idx == count) state_next = colstd_pkg::ST_SQRD;
      colstd_pkg::ST_SQRD:  if (idx == count) state_next = colstd_pkg::ST_ROOT;
                            else state_next = colstd_pkg::ST_SQ;
      colstd_pkg::ST_SQ:    state_next = colstd_pkg::ST_SQRD;
      colstd_pkg::ST_ROOT:  if (rt_step == 6'd0) state_next = colstd_pkg::ST_EMRD;
      colstd_pkg::ST_EMRD:  if (idx == count) state_next = colstd_pkg::ST_LOAD;
                            else state_next = colstd_pkg::ST_DIV;
      colstd_pkg::ST_DIV:   if (dv_done) state_next = colstd_pkg::ST_OUT;
      colstd_pkg::ST_OUT:   if (result_ready) state_next = colstd_pkg::ST_EMRD;
      default:              state_next = colstd_pkg::ST_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    sample_ready = (state == colstd_pkg::ST_LOAD);
    result_valid = (state == colstd_pkg::ST_OUT);
    dv_start     = (state == colstd_pkg::ST_DIV) && div_armed && !div_launched;
  end

  assign sq_prod = sc_mag * sc_mag;

  // Saturate and apply sign
  always_comb begin
    if (sc_neg) begin
      out_val = (dv_quo > colstd_pkg::QuoW'(33'h080000000)) ? 32'h80000000
              : 32'(-dv_quo);
    end else begin
      out_val = (dv_quo > colstd_pkg::QuoW'(33'h07FFFFFFF)) ? 32'h7FFFFFFF
              : dv_quo[31:0];
    end
  end

  // Root: bit-pair restoring square root, two bits of S per cycle
  logic [colstd_pkg::SqW-1:0] rt_bit;
  logic [colstd_pkg::SqW-1:0] rt_res;
  assign rt_bit = colstd_pkg::SqW'(1) << {rt_step - 6'd1, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= colstd_pkg::ST_LOAD;
      count        <= '0;
      sum          <= '0;
      ovf          <= 1'b0;
      nonzero      <= 1'b0;
      idx          <= '0;
      div_armed    <= 1'b0;
      div_launched <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        colstd_pkg::ST_LOAD: begin
          if (sample_valid) begin
            // Drop samples past the buffer depth
            if (count < CntW'(MAX_SAMPLES)) begin
              count <= count + 1'b1;
              sum   <= sum + SumW'($signed(sample));
              if (sample != '0) nonzero <= 1'b1;
            end else begin
              ovf <= 1'b1;
            end
            idx    <= '0;
            maxmag <= '0;
          end
        end
        colstd_pkg::ST_MAXRD: idx <= idx + 1'b1;
        colstd_pkg::ST_MAX: begin
          if (dev_mag > maxmag) maxmag <= dev_mag;
          if (idx == count) idx <= '0;
          else idx <= idx + 1'b1;
          sq_acc <= '0;
        end
        colstd_pkg::ST_SQRD: begin
          // Accumulate the square captured in the previous cycle
          sq_acc <= sq_acc + colstd_pkg::SqW'(sq_prod);
          if (idx == count) begin
            rt_step <= 6'd32;
            rt_v    <= sq_acc + colstd_pkg::SqW'(sq_prod);
            rt_res  <= '0;
            idx     <= '0;
          end
        end
        colstd_pkg::ST_SQ: begin
          idx <= idx + 1'b1;
        end
        colstd_pkg::ST_ROOT: begin
          if (rt_step != 6'd0) begin
            if (rt_v >= rt_res + rt_bit) begin
              rt_v   <= rt_v - (rt_res + rt_bit);
              rt_res <= (rt_res >> 1) + rt_bit;
            end else begin
              rt_res <= rt_res >> 1;
            end
            rt_step <= rt_step - 1'b1;
          end else begin
            root <= (maxmag == '0 || rt_res == '0) ? colstd_pkg::RootW'(1)
                                                  : rt_res[colstd_pkg::RootW-1:0];
          end
        end
        colstd_pkg::ST_EMRD: begin
          if (idx == count) begin
            count   <= '0;
            sum     <= '0;
            ovf     <= 1'b0;
            nonzero <= 1'b0;
          end
        end
        colstd_pkg::ST_DIV: begin
          // Capture operands, then launch, then wait for the quotient
          if (dv_done) begin
            div_armed    <= 1'b0;
            div_launched <= 1'b0;
          end else if (!div_armed) begin
            div_armed <= 1'b1;
          end else begin
            div_launched <= 1'b1;
          end
        end
        colstd_pkg::ST_OUT: begin
          if (result_ready) idx <= idx + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Capture the scaled magnitude for the square pass and for the divider
  always_ff @(posedge clk) begin
    if (state == colstd_pkg::ST_MAX) begin
      sc_mag <= '0;
    end else if (state == colstd_pkg::ST_SQ ||
                 (state == colstd_pkg::ST_DIV && !div_armed)) begin
      sc_mag <= scaled;
      sc_neg <= dev_neg;
    end
    if (dv_done) begin
      normalized  <= out_val;
      last_result <= (idx + 1'b1 == count);
      status      <= ovf ? colstd_pkg::StatusOverflow
                   : (maxmag == '0 && nonzero) ? colstd_pkg::StatusZeroDev
                   : colstd_pkg::StatusOk;
    end
  end

  // Assertions
  a_no_both: assert property (@(posedge clk) disable iff (rst)
    !(sample_ready && result_valid)) else $error("ready during output");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(MAX_SAMPLES)) else $error("count past depth");
  a_out_after_div: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(dv_done)) else $error("result without divide");

endmodule : column_standardizer
`default_nettype wire

### hw/rtl/colstd_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// colstd_div
// Restoring radix-2 divider, one quotient bit per cycle, for the final
// quotient of each standardized sample.
// ----------------------------------------------------------------------------
module colstd_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [colstd_pkg::NumW-1:0]      dividend,
  input  wire logic [colstd_pkg::RootW-1:0]     divisor,
  output logic                                  done,
  output logic [colstd_pkg::QuoW-1:0]           quotient
);

  localparam int NumW  = colstd_pkg::NumW;
  localparam int RootW = colstd_pkg::RootW;
  localparam int QuoW  = colstd_pkg::QuoW;
  localparam int CntW  = $clog2(NumW + 1);

  logic [NumW-1:0]    num;
  logic [RootW:0]     rem;
  logic [RootW-1:0]   den;
  logic [CntW-1:0]    cnt;
  logic               busy;
  logic [RootW:0]     trial;
  logic [RootW+1:0]   diff;

  assign trial = {rem[RootW-1:0], num[NumW-1]};
  assign diff  = {1'b0, trial} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(NumW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num      <= dividend;
      den      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      num <= {num[NumW-2:0], 1'b0};
      rem <= diff[RootW+1] ? trial : diff[RootW:0];
      // Hold the top bit sticky so an oversized quotient still saturates
      quotient <= {quotient[QuoW-1] | quotient[QuoW-2], quotient[QuoW-3:0],
                   ~diff[RootW+1]};
    end
  end

endmodule : colstd_div
`default_nettype wire

### verif/tb_column_standardizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_column_standardizer
// Streams columns of Q16.16 samples into the standardizer and checks every
// Q2.30 z-score, end mark and status against an in-bench integer model.
// ----------------------------------------------------------------------------
module tb_column_standardizer;

  localparam int MaxCol     = 64;
  localparam int IdleLimit  = 6000;   // cycles with no transfer on either side
  localparam int DrainCycles = 400;   // settle time once nothing is owed

  typedef struct {
    logic [31:0] value;
    logic        last;
    logic [1:0]  stat;
  } zscore_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        sample_valid = 1'b0;
  logic        sample_ready;
  logic [31:0] sample = '0;
  logic        last_sample = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [31:0] normalized;
  logic        last_result;
  logic [1:0]  status;

  // Column being collected by the model, and results owed by the block.
  int signed   col_vals[$];
  longint      col_sum;
  bit          col_dropped;
  zscore_t     pending_scores[$];
  int          errors;
  int          items_sent;
  int          idle_cycles;

  column_standardizer dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_ready(sample_ready),
    .sample(sample), .last_sample(last_sample),
    .result_valid(result_valid), .result_ready(result_ready),
    .normalized(normalized), .last_result(last_result), .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bitwise integer square root, floor.
  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Standardize the collected column and queue one score per stored sample.
  function automatic void standardize_column();
    int          n;
    longint      dev;
    logic [63:0] mag[MaxCol];
    bit          neg[MaxCol];
    logic [63:0] maxmag, sumsq, root, quo;
    bit          any_nz;
    int          len;
    logic [1:0]  st;
    zscore_t     z;
    n = col_vals.size();
    maxmag = '0;
    sumsq = '0;
    any_nz = 1'b0;
    for (int i = 0; i < n; i++) begin
      dev = longint'(n) * longint'(col_vals[i]) - col_sum;
      neg[i] = dev < 0;
      mag[i] = neg[i] ? 64'(-dev) : 64'(dev);
      if (mag[i] > maxmag) maxmag = mag[i];
      if (col_vals[i] != 0) any_nz = 1'b1;
    end
    st = col_dropped ? colstd_pkg::StatusOverflow : colstd_pkg::StatusOk;
    if (maxmag == 0) begin
      // Flat column: zeros out, flag it only when the values are nonzero.
      if (any_nz && st == colstd_pkg::StatusOk) st = colstd_pkg::StatusZeroDev;
      root = 64'd1;
    end else begin
      // Normalize so the largest deviation lands in [2^28, 2^29).
      len = 0;
      while (len < 64 && (maxmag >> len) != 0) len++;
      for (int i = 0; i < n; i++) begin
        if (len > 29) mag[i] = mag[i] >> (len - 29);
        else if (len < 29) mag[i] = mag[i] << (29 - len);
        sumsq += mag[i] * mag[i];
      end
      root = int_sqrt(sumsq);
      if (root == 0) root = 64'd1;
    end
    for (int i = 0; i < n; i++) begin
      quo = ((mag[i] << 30) + (root >> 1)) / root;
      if (neg[i]) begin
        if (quo > 64'h8000_0000) quo = 64'h8000_0000;
        z.value = 32'(-quo);
      end else begin
        if (quo > 64'h7FFF_FFFF) quo = 64'h7FFF_FFFF;
        z.value = quo[31:0];
      end
      z.last = (i + 1 == n);
      z.stat = st;
      pending_scores.push_back(z);
    end
    col_vals.delete();
    col_sum = 0;
    col_dropped = 1'b0;
  endfunction

  // Send one sample and hold it until the transfer, then update the model.
  task automatic send_sample(logic [31:0] val, logic mark);
    sample_valid <= 1'b1;
    sample       <= val;
    last_sample  <= mark;
    do @(posedge clk); while (!sample_ready);
    items_sent++;
    if (col_vals.size() < MaxCol) begin
      col_vals.push_back(int'(val));
      col_sum += longint'($signed(val));
    end else begin
      col_dropped = 1'b1;
    end
    if (mark) standardize_column();
  endtask

  // Drop valid for a random gap: mostly none, sometimes short, rarely long.
  task automatic sender_gap();
    int pick, len;
    pick = $urandom_range(0, 99);
    if (pick < 65) len = 0;
    else if (pick < 95) len = $urandom_range(1, 3);
    else len = $urandom_range(10, 40);
    if (len > 0) begin
      sample_valid <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  task automatic send_column(logic [31:0] vals[$]);
    foreach (vals[i]) begin
      send_sample(vals[i], i == vals.size() - 1);
      sender_gap();
    end
  endtask

  // Hold off the sender until every owed score has come back.
  task automatic wait_for_drain();
    sample_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [31:0] vals[$];
    vals = {32'h0000_0000};                            // single zero
    send_column(vals);
    vals = {32'h0001_0000};                            // single nonzero
    send_column(vals);
    vals = {32'h7FFF_FFFF, 32'h8000_0000};             // full-scale pair
    send_column(vals);
    vals = {32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
    send_column(vals);
    vals = {32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000};
    send_column(vals);
    vals = {32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF,
            32'h0000_0002, 32'h0000_0000};             // tiny deviations
    send_column(vals);
    vals = {32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
    send_column(vals);
    vals = {32'h0003_0000, 32'h5555_AAAA, 32'hAAAA_5555};
    send_column(vals);
    wait_for_drain();
  endtask

  task automatic test_overflow();
    logic [31:0] vals[$];
    // Marked sample falls past the buffer and is dropped.
    for (int i = 0; i < MaxCol + 2; i++) vals.push_back($urandom());
    send_column(vals);
    // Flat nonzero column that also overflows: overflow status wins.
    vals.delete();
    for (int i = 0; i < MaxCol + 1; i++) vals.push_back(32'h0002_0000);
    send_column(vals);
    wait_for_drain();
  endtask

  task automatic test_random_columns();
    logic [31:0] vals[$];
    logic [31:0] base;
    int len, mode;
    while (items_sent < 330) begin
      vals.delete();
      len = ($urandom_range(0, 15) == 0) ? MaxCol : $urandom_range(1, 12);
      mode = $urandom_range(0, 9);
      base = $urandom();
      for (int i = 0; i < len; i++) begin
        case (mode)
          0: vals.push_back(base);                                    // flat
          1, 2: vals.push_back(32'($signed($urandom_range(0, 2000)) - 1000));
          3: vals.push_back(base + $urandom_range(0, 3));             // near flat
          default: vals.push_back($urandom());
        endcase
      end
      send_column(vals);
    end
  endtask

  // Random receiver stalls; ready is drawn anew each clock and is mostly high.
  always @(posedge clk) begin
    int pick;
    pick = $urandom_range(0, 99);
    if (rst) result_ready <= 1'b0;
    else if (pick < 40) result_ready <= 1'b1;
    else if (pick < 95) result_ready <= ($urandom_range(0, 2) != 0);
    else result_ready <= 1'b0;
  end

  // Compare each accepted score against the oldest owed one.
  always @(posedge clk) begin
    zscore_t z;
    if (!rst && result_valid && result_ready) begin
      if (pending_scores.size() == 0) begin
        $error("unexpected result: normalized %h last %b status %0d",
               normalized, last_result, status);
        errors++;
      end else begin
        z = pending_scores.pop_front();
        if (normalized !== z.value) begin
          $error("normalized: expected %h, got %h", z.value, normalized);
          errors++;
        end
        if (last_result !== z.last) begin
          $error("last_result: expected %b, got %b", z.last, last_result);
          errors++;
        end
        if (status !== z.stat) begin
          $error("status: expected %0d, got %0d", z.stat, status);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    errors = 0;
    items_sent = 0;
    idle_cycles = 0;
    col_sum = 0;
    col_dropped = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_random_columns();
    wait_for_drain();
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && pending_scores.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
